// ===== hdl/fbpa_pkg.sv =====
// Package for the fixed block pool allocator.
// Holds item types, command and status structs, codes and descriptor layout.
// No dependencies.
package fbpa_pkg;

  // Field widths of the items.
  localparam int MODE_W     = 2;
  localparam int REQ_W      = 12;
  localparam int BUF_W      = 2;
  localparam int OFF_W      = 15;
  localparam int BYTES_W    = 10;
  localparam int STATUS_W   = 2;
  localparam int REL_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Descriptor layout: long-term flag, buffer index, block count, size in 128-byte units.
  localparam int DESC_W       = 8;
  localparam int NUM_DESC     = 5;
  localparam int SIZE_LSB     = 0;
  localparam int SIZE_W       = 3;
  localparam int CNT_LSB      = 3;
  localparam int CNT_W        = 2;
  localparam int DBUF_LSB     = 5;
  localparam int LT_BIT       = 7;
  localparam int UNIT_SHIFT   = 7;
  localparam int BLK_PER_SET  = 3;

  // Running block position and set counter widths.
  localparam int BLK_POS_W = 5;
  localparam int SET_IDX_W = 3;
  localparam int PICK_W    = 2;

  localparam logic [DESC_W-1:0] DESC_RST [NUM_DESC] = '{
    8'd137, 8'd140, 8'd44, 8'd77, 8'd109
  };
  localparam logic [BYTES_W-1:0] MAX_REQ_RST = 10'd600;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_ALLOC    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_BLOCK  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_BUFFER = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DESC_LAST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEDICATED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQ   = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [REQ_W-1:0]  request_bytes;
    logic              long_term;
    logic [BUF_W-1:0]  addr_buffer;
    logic [OFF_W-1:0]  addr_offset;
    logic              buffer_granted;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BUF_W-1:0]    out_buffer;
    logic [OFF_W-1:0]    out_offset;
    logic [BYTES_W-1:0]  block_bytes;
    logic                acquire_buffer;
    logic [REL_W-1:0]    release_mask;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic                 load;
    logic                 step;
    logic                 commit;
    logic [SET_IDX_W-1:0] set_idx;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic skip_scan;
  } dp_sts_t;

endpackage

// ===== hdl/fbpa_chan_if.sv =====
// Valid/ready channel interface used by every channel port of the allocator.
// The payload type is a parameter; no other dependencies.
interface fbpa_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator.
// Depends on fbpa_pkg, fbpa_chan_if, fbpa_ctrl and fbpa_dp.
//
//   Channel   Direction  Payload  Purpose
//   req_i     in         req_t    allocate, free, query or shutdown item
//   rsp_o     out        rsp_t    one result item per request item
//   cfg_i     in         cfg_t    register write: set descriptors, mode, max size
//
// A request item passes through an accept state, one scan step for each of the
// first min(NUM_SETS, 5) set descriptors and a finish state. A shutdown item
// leaves the scan state at once for the finish state without a scan step.
// Reset is asynchronous and active low; all sets come back to their default
// descriptors, every block is free and no backing buffer is held.
// The finish cycle waits while the previous result is still unread; a new
// request is taken while a result sits in the output register.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int NUM_SETS    = 5,
  parameter int NUM_BUFFERS = 4,
  parameter int NUM_BLOCKS  = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fbpa_chan_if.sink    req_i,
  fbpa_chan_if.source  rsp_o,
  fbpa_chan_if.sink    cfg_i
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  req_t      req_item;
  rsp_t      rsp_item;
  cfg_t      cfg_item;
  logic      cfg_we;

  // Register writes are always taken; the user only writes while the block
  // has nothing in flight.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign cfg_item    = cfg_i.data;
  assign req_item    = req_i.data;

  // The controller walks the set descriptors, one per cycle, and owns the
  // valid flag of the result register.
  fbpa_ctrl #(
    .NUM_SETS (NUM_SETS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath decodes each set into its block offsets, picks the first
  // free or matching block, and keeps block-in-use and buffer-held bits.
  fbpa_dp #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .item_i   (req_item),
    .cfg_we_i (cfg_we),
    .cfg_i    (cfg_item),
    .rsp_o    (rsp_item)
  );

  assign rsp_o.data = rsp_item;

endmodule

// ===== hdl/fbpa_ctrl.sv =====
// Controller of the allocator: accepts items, sequences the set scan and
// hands results to the output register. Depends on fbpa_pkg.
module fbpa_ctrl import fbpa_pkg::*; #(
  parameter int NUM_SETS = 5
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam int SCAN_SETS = (NUM_SETS < NUM_DESC) ? NUM_SETS : NUM_DESC;
  localparam logic [SET_IDX_W-1:0] LAST_SET = SET_IDX_W'(SCAN_SETS - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [SET_IDX_W-1:0] set_q, set_d;
  logic                 out_vld_q, out_vld_d;

  always_comb begin
    state_d    = state_q;
    set_d      = set_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          set_d      = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.skip_scan) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.step = 1'b1;
          set_d      = set_q + 1'b1;
          if (set_q == LAST_SET) begin
            state_d = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        // The previous result must have left the output register.
        if (!out_vld_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.set_idx = set_q;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_vld_d = 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      set_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      set_q     <= set_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== hdl/fbpa_dp.sv =====
// Datapath of the allocator: configuration, block and buffer state, one set
// decoded per scan step, and the result register. Depends on fbpa_pkg.
module fbpa_dp import fbpa_pkg::*; #(
  parameter int NUM_BUFFERS = 4,
  parameter int NUM_BLOCKS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  output dp_sts_t   sts_o,
  input  req_t      item_i,
  input  logic      cfg_we_i,
  input  cfg_t      cfg_i,
  output rsp_t      rsp_o
);

  localparam logic [BUF_W:0]     BUF_LIMIT = (BUF_W + 1)'(NUM_BUFFERS);
  localparam logic [BLK_POS_W:0] BLK_LIMIT = (BLK_POS_W + 1)'(NUM_BLOCKS);
  localparam int                 OFF_SLOTS = 1 << BUF_W;

  logic [DESC_W-1:0]      desc_q [NUM_DESC];
  logic [DESC_W-1:0]      desc_d [NUM_DESC];
  logic                   ded_q, ded_d;
  logic [BYTES_W-1:0]     max_q, max_d;
  logic [NUM_BLOCKS-1:0]  used_q, used_d;
  logic [NUM_BUFFERS-1:0] pres_q, pres_d;
  logic                   hit_q, hit_d;

  req_t                   item_q, item_d;
  logic                   size_ok_q, size_ok_d;
  logic [OFF_W-1:0]       next_off_q [OFF_SLOTS];
  logic [OFF_W-1:0]       next_off_d [OFF_SLOTS];
  logic [BLK_POS_W-1:0]   blk_pos_q, blk_pos_d;
  logic [NUM_BLOCKS-1:0]  bm_q, bm_d;
  rsp_t                   res_q, res_d;
  rsp_t                   out_q, out_d;

  // Decode of the set under scan.
  logic [DESC_W-1:0]     desc;
  logic [SIZE_W-1:0]     size_u;
  logic [BYTES_W-1:0]    size_b;
  logic [CNT_W-1:0]      cnt;
  logic [BUF_W-1:0]      bi;
  logic                  set_lt;
  logic                  set_exists;
  logic                  pres_sel;
  logic                  pres_bi;
  logic [OFF_W-1:0]      base;
  logic [OFF_W-1:0]      span;
  logic [BLK_POS_W-1:0]  pos [BLK_PER_SET];
  logic [OFF_W-1:0]      offs [BLK_PER_SET];
  logic [NUM_BLOCKS-1:0] sel [BLK_PER_SET];
  logic [BLK_PER_SET-1:0] in_set;
  logic [BLK_PER_SET-1:0] used_at;
  logic [BLK_PER_SET-1:0] cand;
  logic [NUM_BLOCKS-1:0] set_mask;
  logic                  do_alloc;
  logic                  do_match;
  logic                  pick_any;
  logic [PICK_W-1:0]     pick_j;

  always_comb begin
    desc   = desc_q[cmd_i.set_idx];
    size_u = desc[SIZE_LSB +: SIZE_W];
    size_b = {size_u, {UNIT_SHIFT{1'b0}}};
    cnt    = desc[CNT_LSB +: CNT_W];
    bi     = ded_q ? '0 : desc[DBUF_LSB +: BUF_W];
    set_lt = desc[LT_BIT];
    set_exists = ({1'b0, bi} < BUF_LIMIT);

    pres_sel = 1'b0;
    for (int b = 0; b < NUM_BUFFERS; b++) begin
      if (BUF_W'(b) == bi) begin
        pres_sel = pres_q[b];
      end
    end
    // A dedicated buffer is always there.
    pres_bi = ded_q | pres_sel;

    base = next_off_q[bi];
    span = (cnt[0] ? OFF_W'(size_b) : '0) + (cnt[1] ? OFF_W'({size_b, 1'b0}) : '0);

    offs[0] = base;
    offs[1] = base + OFF_W'(size_b);
    offs[2] = base + OFF_W'({size_b, 1'b0});

    for (int j = 0; j < BLK_PER_SET; j++) begin
      pos[j]     = blk_pos_q + BLK_POS_W'(j);
      in_set[j]  = (CNT_W'(j) < cnt) && ({1'b0, pos[j]} < BLK_LIMIT);
      for (int k = 0; k < NUM_BLOCKS; k++) begin
        sel[j][k] = (BLK_POS_W'(k) == pos[j]);
      end
      used_at[j] = |(used_q & sel[j]);
    end

    for (int k = 0; k < NUM_BLOCKS; k++) begin
      set_mask[k] = ((BLK_POS_W + 1)'(k) >= {1'b0, blk_pos_q}) &&
                    ((BLK_POS_W + 1)'(k) < ({1'b0, blk_pos_q} + (BLK_POS_W + 1)'(cnt)));
    end

    // Short-term requests skip long-term sets.
    do_alloc = (item_q.mode == MODE_ALLOC) && size_ok_q && !hit_q && set_exists &&
               (item_q.request_bytes <= REQ_W'(size_b)) && !(set_lt && !item_q.long_term);
    // Only the exact start of a non-empty block in a present buffer matches.
    do_match = ((item_q.mode == MODE_FREE) || (item_q.mode == MODE_QUERY)) && !hit_q &&
               set_exists && (bi == item_q.addr_buffer) && pres_bi && (size_u != '0);

    for (int j = 0; j < BLK_PER_SET; j++) begin
      cand[j] = (do_alloc && in_set[j] && !used_at[j]) ||
                (do_match && in_set[j] && (item_q.addr_offset == offs[j]));
    end

    pick_any = 1'b0;
    pick_j   = '0;
    for (int j = BLK_PER_SET - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pick_any = 1'b1;
        pick_j   = PICK_W'(j);
      end
    end
  end

  always_comb begin
    desc_d     = desc_q;
    ded_d      = ded_q;
    max_d      = max_q;
    used_d     = used_q;
    pres_d     = pres_q;
    hit_d      = hit_q;
    item_d     = item_q;
    size_ok_d  = size_ok_q;
    next_off_d = next_off_q;
    blk_pos_d  = blk_pos_q;
    bm_d       = bm_q;
    res_d      = res_q;
    out_d      = out_q;

    if (cfg_we_i) begin
      if (cfg_i.reg_idx <= REG_DESC_LAST) begin
        desc_d[cfg_i.reg_idx] = cfg_i.wdata[DESC_W-1:0];
      end else if (cfg_i.reg_idx == REG_DEDICATED) begin
        ded_d = cfg_i.wdata[0];
      end else if (cfg_i.reg_idx == REG_MAX_REQ) begin
        max_d = cfg_i.wdata[BYTES_W-1:0];
      end
    end

    if (cmd_i.load) begin
      item_d    = item_i;
      size_ok_d = (item_i.request_bytes != '0) &&
                  (item_i.request_bytes <= REQ_W'(max_q));
      for (int b = 0; b < OFF_SLOTS; b++) begin
        next_off_d[b] = '0;
      end
      blk_pos_d = '0;
      hit_d     = 1'b0;
      bm_d      = '0;
      res_d     = '0;
      case (item_i.mode)
        MODE_ALLOC:    res_d.status = STATUS_NO_BLOCK;
        MODE_FREE:     res_d.status = STATUS_NOT_FOUND;
        MODE_QUERY:    res_d.status = STATUS_NOT_FOUND;
        default:       res_d.status = STATUS_OK;
      endcase
    end

    if (cmd_i.step) begin
      next_off_d[bi] = base + span;
      blk_pos_d      = blk_pos_q + BLK_POS_W'(cnt);
      if ((item_q.mode == MODE_FREE) && set_exists && (bi == item_q.addr_buffer)) begin
        bm_d = bm_q | set_mask;
      end
      if (pick_any) begin
        hit_d = 1'b1;
        if (item_q.mode == MODE_ALLOC) begin
          if (!pres_bi && !item_q.buffer_granted) begin
            res_d.status = STATUS_NO_BUFFER;
          end else begin
            if (!pres_bi) begin
              for (int b = 0; b < NUM_BUFFERS; b++) begin
                if (BUF_W'(b) == bi) begin
                  pres_d[b] = 1'b1;
                end
              end
              res_d.acquire_buffer = 1'b1;
            end
            used_d            = used_q | sel[pick_j];
            res_d.status      = STATUS_OK;
            res_d.out_buffer  = bi;
            res_d.out_offset  = offs[pick_j];
            res_d.block_bytes = size_b;
          end
        end else begin
          res_d.status = STATUS_OK;
          if (item_q.mode == MODE_QUERY) begin
            res_d.block_bytes = size_b;
          end else begin
            used_d = used_q & ~sel[pick_j];
          end
        end
      end
    end

    if (cmd_i.commit) begin
      out_d = res_q;
      if (item_q.mode == MODE_SHUTDOWN) begin
        out_d.release_mask = ded_q ? '0 : REL_W'(pres_q);
        used_d = '0;
        pres_d = '0;
        ded_d  = 1'b0;
      end else if ((item_q.mode == MODE_FREE) && (res_q.status == STATUS_OK) && !ded_q &&
                   ((used_q & bm_q) == '0)) begin
        // Last block of the buffer has gone: hand the buffer back.
        for (int b = 0; b < NUM_BUFFERS; b++) begin
          if (BUF_W'(b) == item_q.addr_buffer) begin
            pres_d[b] = 1'b0;
          end
        end
        out_d.release_mask = REL_W'(1) << item_q.addr_buffer;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= DESC_RST;
      ded_q  <= 1'b0;
      max_q  <= MAX_REQ_RST;
      used_q <= '0;
      pres_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      desc_q <= desc_d;
      ded_q  <= ded_d;
      max_q  <= max_d;
      used_q <= used_d;
      pres_q <= pres_d;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    size_ok_q  <= size_ok_d;
    next_off_q <= next_off_d;
    blk_pos_q  <= blk_pos_d;
    bm_q       <= bm_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign sts_o.skip_scan = (item_q.mode == MODE_SHUTDOWN);
  assign rsp_o           = out_q;

endmodule

// ===== hdl/fbpa_checker.sv =====
// Port-level checks of the allocator and the bind that attaches them.
// Depends on fbpa_pkg and fixed_block_pool_allocator.
module fbpa_checker import fbpa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_i
);

  logic       req_acc;
  logic       rsp_acc;
  logic [1:0] pend_q, pend_d;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (req_acc && !rsp_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (!req_acc && rsp_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // No result without an item that asked for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_acc |-> (pend_q != 2'd0))
    else $error("result delivered with no item outstanding");

  // At most one item in work and one result waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> (pend_q != 2'd2) && (pend_q != 2'd3))
    else $error("item accepted while two are outstanding");

  // Block sizes come in whole 128-byte units.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_i.block_bytes[6:0] == 7'd0))
    else $error("block size is not a multiple of 128");

  // A failed item reports nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_i.status != STATUS_OK)) |->
      (rsp_i.out_buffer == '0) && (rsp_i.out_offset == '0) &&
      (rsp_i.block_bytes == '0) && !rsp_i.acquire_buffer && (rsp_i.release_mask == '0))
    else $error("failed result carries a block or buffer change");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i && $stable(rsp_i))
    else $error("stalled result changed");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.data)
);
